/* sv/fhal_pkg.sv */
package fhal_pkg;

   localparam int HEAP_BYTES_DEF   = 64 * 1024;
   localparam int HEADER_BYTES_DEF = 12;

   // working width for offsets, lengths and rounded sizes
   localparam int CALC_W = 18;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_REINIT  = 2'd2;

   localparam logic [CALC_W-1:0] ROUND_ADD  = CALC_W'(7);
   localparam logic [CALC_W-1:0] ROUND_MASK = ~CALC_W'(7);
   localparam logic [CALC_W-1:0] MIN_SPLIT  = CALC_W'(8);

   typedef struct packed {
      logic        idle;
      logic        done;
      logic        granted;
      logic [15:0] payload_address;
   } status_type;

endpackage

/* sv/fhal_req_if.sv */
interface fhal_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] request_bytes;
   logic [15:0] block_address;

   modport source (output valid, output cmd, output request_bytes, output block_address,
                   input ready);
   modport sink (input valid, input cmd, input request_bytes, input block_address,
                 output ready);
endinterface

/* sv/fhal_rsp_if.sv */
interface fhal_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [15:0] payload_address;

   modport source (output valid, output granted, output payload_address, input ready);
   modport sink (input valid, input granted, input payload_address, output ready);
endinterface

/* sv/fhal_mem.sv */
module fhal_mem import fhal_pkg::*; #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/fhal_ctrl.sv */
module fhal_ctrl import fhal_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int SLOTS        = HEAP_BYTES / HEADER_BYTES + 1,
   parameter int ADDR_W       = $clog2(SLOTS),
   parameter int LEN_W        = $clog2(HEAP_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        cmd,
   input  logic [15:0]       request_bytes,
   input  logic [15:0]       block_address,
   output status_type        status,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [LEN_W:0]    mem_wdata,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [LEN_W:0]    mem_rdata
);

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CALC_W-1:0] HDR_C  = CALC_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0]  INIT_L = LEN_W'(HEAP_BYTES - HEADER_BYTES);

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_AREAD  = 14'b00000000000100,
      S_ACHK   = 14'b00000000001000,
      S_SHRD   = 14'b00000000010000,
      S_SHWR   = 14'b00000000100000,
      S_SPLIT  = 14'b00000001000000,
      S_SPLIT2 = 14'b00000010000000,
      S_RREAD  = 14'b00000100000000,
      S_RCHK   = 14'b00001000000000,
      S_MRD    = 14'b00010000000000,
      S_MCHK   = 14'b00100000000000,
      S_MFIN   = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  k_ff, k_in, live_ff, live_in, j_ff, j_in, w_ff, w_in;
   logic [CALC_W-1:0] off_ff, off_in, want_ff, want_in, rem_ff, rem_in;
   logic [CALC_W-1:0] cur_len_ff, cur_len_in;
   logic              cur_free_ff, cur_free_in, have_ff, have_in;
   logic [15:0]       addr_ff, addr_in, pa_ff, pa_in;
   logic              gr_ff, gr_in, report_ff, report_in;

   logic              rd_free;
   logic [CALC_W-1:0] rd_len, next_off, pay_off;

   assign rd_free  = mem_rdata[LEN_W];
   assign rd_len   = CALC_W'(mem_rdata[LEN_W-1:0]);
   assign next_off = off_ff + HDR_C + rd_len;
   assign pay_off  = off_ff + HDR_C;

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      live_in     = live_ff;
      j_in        = j_ff;
      w_in        = w_ff;
      off_in      = off_ff;
      want_in     = want_ff;
      rem_in      = rem_ff;
      cur_len_in  = cur_len_ff;
      cur_free_in = cur_free_ff;
      have_in     = have_ff;
      addr_in     = addr_ff;
      pa_in       = pa_ff;
      gr_in       = gr_ff;
      report_in   = report_ff;
      mem_we      = 1'b0;
      mem_waddr   = k_ff[ADDR_W-1:0];
      mem_wdata   = {1'b0, rd_len[LEN_W-1:0]};
      mem_raddr   = k_ff[ADDR_W-1:0];
      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {1'b1, INIT_L};
            live_in   = CNT_W'(1);
            state_in  = report_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               k_in      = '0;
               off_in    = '0;
               want_in   = (CALC_W'(request_bytes) + ROUND_ADD) & ROUND_MASK;
               addr_in   = block_address;
               gr_in     = 1'b0;
               pa_in     = '0;
               report_in = 1'b0;
               case (cmd)
                  CMD_ALLOC: state_in = S_AREAD;
                  CMD_RELEASE: begin
                     if (block_address == 16'd0) begin
                        gr_in    = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RREAD;
                     end
                  end
                  CMD_REINIT: begin
                     gr_in     = 1'b1;
                     report_in = 1'b1;
                     state_in  = S_INIT;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_AREAD: begin
            state_in = (k_ff == live_ff) ? S_DONE : S_ACHK;
         end
         S_ACHK: begin
            if (rd_free && rd_len >= want_ff) begin
               gr_in = 1'b1;
               pa_in = pay_off[15:0];
               if (rd_len >= want_ff + HDR_C + MIN_SPLIT) begin
                  rem_in   = rd_len - want_ff - HDR_C;
                  j_in     = live_ff - CNT_W'(1);
                  state_in = S_SHRD;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b0, rd_len[LEN_W-1:0]};
                  state_in  = S_DONE;
               end
            end else begin
               off_in   = next_off;
               k_in     = k_ff + CNT_W'(1);
               state_in = S_AREAD;
            end
         end
         // move entries k+1..live-1 up one slot, top down
         S_SHRD: begin
            mem_raddr = j_ff[ADDR_W-1:0];
            state_in  = (j_ff == k_ff) ? S_SPLIT : S_SHWR;
         end
         S_SHWR: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(j_ff + CNT_W'(1));
            mem_wdata = mem_rdata;
            j_in      = j_ff - CNT_W'(1);
            state_in  = S_SHRD;
         end
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(k_ff + CNT_W'(1));
            mem_wdata = {1'b1, rem_ff[LEN_W-1:0]};
            state_in  = S_SPLIT2;
         end
         S_SPLIT2: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, want_ff[LEN_W-1:0]};
            live_in   = live_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_RREAD: begin
            state_in = (k_ff == live_ff) ? S_DONE : S_RCHK;
         end
         S_RCHK: begin
            if (pay_off == CALC_W'(addr_ff)) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, rd_len[LEN_W-1:0]};
               k_in      = '0;
               w_in      = '0;
               have_in   = 1'b0;
               state_in  = S_MRD;
            end else begin
               off_in   = next_off;
               k_in     = k_ff + CNT_W'(1);
               state_in = S_RREAD;
            end
         end
         // merge pass: k reads, w counts written entries, cur is the open entry
         S_MRD: begin
            state_in = (k_ff == live_ff) ? S_MFIN : S_MCHK;
         end
         S_MCHK: begin
            if (have_ff && cur_free_ff && rd_free) begin
               cur_len_in = cur_len_ff + HDR_C + rd_len;
            end else begin
               if (have_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = w_ff[ADDR_W-1:0];
                  mem_wdata = {cur_free_ff, cur_len_ff[LEN_W-1:0]};
                  w_in      = w_ff + CNT_W'(1);
               end
               cur_len_in  = rd_len;
               cur_free_in = rd_free;
               have_in     = 1'b1;
            end
            k_in     = k_ff + CNT_W'(1);
            state_in = S_MRD;
         end
         S_MFIN: begin
            mem_we    = 1'b1;
            mem_waddr = w_ff[ADDR_W-1:0];
            mem_wdata = {cur_free_ff, cur_len_ff[LEN_W-1:0]};
            live_in   = w_ff + CNT_W'(1);
            gr_in     = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         report_ff <= 1'b0;
         have_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
         have_ff   <= have_in;
      end
      k_ff        <= k_in;
      live_ff     <= live_in;
      j_ff        <= j_in;
      w_ff        <= w_in;
      off_ff      <= off_in;
      want_ff     <= want_in;
      rem_ff      <= rem_in;
      cur_len_ff  <= cur_len_in;
      cur_free_ff <= cur_free_in;
      addr_ff     <= addr_in;
      pa_ff       <= pa_in;
      gr_ff       <= gr_in;
   end

   assign status.idle            = (state_ff == S_IDLE);
   assign status.done            = (state_ff == S_DONE);
   assign status.granted         = gr_ff;
   assign status.payload_address = pa_ff;

endmodule

/* sv/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing. The heap is kept as a chain of
// contiguous blocks, one word per block (payload length and free mark) in a
// single-port-read memory. Commands: allocate (size rounded up to 8, first
// free block that fits, split when the rest holds a header plus 8 bytes),
// release (mark free, then merge every adjacent free pair) and reinitialize.
// One command at a time; each walks the chain one block at a time through the
// registered memory read, an allocate that splits moves the later blocks up
// one slot, and a release is followed by a merge pass over the live blocks.
// After reset the block writes the initial free block before req is ready.
// The response sits in an output register; a new command is taken once that
// register is empty.
module first_fit_heap_allocator import fhal_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   fhal_req_if.sink   req_ch,
   fhal_rsp_if.source rsp_ch
);

   // worst case: every block is a bare header
   localparam int SLOTS  = HEAP_BYTES / HEADER_BYTES + 1;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int LEN_W  = $clog2(HEAP_BYTES + 1);

   status_type        status;
   logic              start;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [LEN_W:0]    mem_wdata, mem_rdata;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_gr_ff, rsp_gr_in;
   logic [15:0]       rsp_pa_ff, rsp_pa_in;

   // accept only when the controller is idle and the response slot is empty
   assign req_ch.ready = status.idle & ~rsp_valid_ff;
   assign start        = req_ch.valid & req_ch.ready;

   fhal_ctrl #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .SLOTS        (SLOTS),
      .ADDR_W       (ADDR_W),
      .LEN_W        (LEN_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .cmd           (req_ch.cmd),
      .request_bytes (req_ch.request_bytes),
      .block_address (req_ch.block_address),
      .status        (status),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   // block chain: {free, length} per block
   fhal_mem #(
      .DEPTH  (SLOTS),
      .WIDTH  (LEN_W + 1),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // response word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_gr_in    = rsp_gr_ff;
      rsp_pa_in    = rsp_pa_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_gr_in    = status.granted;
         rsp_pa_in    = status.payload_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_gr_ff <= rsp_gr_in;
      rsp_pa_ff <= rsp_pa_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.granted         = rsp_gr_ff;
   assign rsp_ch.payload_address = rsp_pa_ff;

endmodule
